// ===== hdl/udul_pkg.sv =====
// Package for the UTF-8 decoder with unique character list.
// Field widths, status and stop codes, lead byte patterns and the default list depth.
// No dependencies.
package udul_pkg;

    // Result field widths
    localparam int CP_W     = 21;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 9;
    localparam int BYTE_W   = 8;

    // Default number of entries in the seen table
    localparam int DEFAULT_LIST_DEPTH = 256;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_POINT      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_END_NORMAL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_END_DECODE = 2'd2;
    localparam logic [STATUS_W-1:0] ST_END_FULL   = 2'd3;

    // Why the list stopped growing
    typedef enum logic [1:0] {
        STOP_NONE   = 2'd0,
        STOP_DECODE = 2'd1,
        STOP_FULL   = 2'd2
    } stop_t;

    // Lead and continuation byte patterns
    localparam logic [BYTE_W-1:0] MASK_LEAD2 = 8'hE0;
    localparam logic [BYTE_W-1:0] PAT_LEAD2  = 8'hC0;
    localparam logic [BYTE_W-1:0] MASK_LEAD3 = 8'hF0;
    localparam logic [BYTE_W-1:0] PAT_LEAD3  = 8'hE0;
    localparam logic [BYTE_W-1:0] MASK_LEAD4 = 8'hF8;
    localparam logic [BYTE_W-1:0] PAT_LEAD4  = 8'hF0;
    localparam logic [BYTE_W-1:0] MASK_CONT  = 8'hC0;
    localparam logic [BYTE_W-1:0] PAT_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] BITS_LEAD2 = 8'h1F;
    localparam logic [BYTE_W-1:0] BITS_LEAD3 = 8'h0F;
    localparam logic [BYTE_W-1:0] BITS_LEAD4 = 8'h07;

    // Smallest legal value for 2, 3 and 4 byte forms
    localparam logic [CP_W-1:0] MIN_CP2 = 21'h00080;
    localparam logic [CP_W-1:0] MIN_CP3 = 21'h00800;
    localparam logic [CP_W-1:0] MIN_CP4 = 21'h10000;

endpackage

// ===== hdl/utf8_decode_unique_list_unit.sv =====
// Top level of the UTF-8 decoder that builds a list of distinct characters.
// Holds the byte decoder, the seen-table memory and its search sequencer.
// Depends on udul_pkg.

// Takes UTF-8 text one byte per item; a zero byte ends the text. Each decoded
// character is reported (status 0, with the new list count) and stored in the
// seen table. With cfg allow_duplicates = 0 a character already in the table is
// dropped without a result. A bad lead, bad continuation, truncated or overlong
// sequence stops the list, as does a full table; the rest of the text is then
// ignored. The zero byte gives one end item with the count and the stop reason
// (1 normal, 2 decode stop, 3 table full) and clears the text state.
// Rate: one byte per cycle while idle and the result slot is free. A byte that
// completes a character while duplicates are off and the list is not empty
// starts a linear search of the entries through the single read port of the
// seen-table memory; no byte is taken until the search ends in a hit or miss.
// The table needs no clearing pass after reset: only entries below the fill
// count are ever read.
module utf8_decode_unique_list_unit
    import udul_pkg::*;
#(
    parameter int LIST_DEPTH = DEFAULT_LIST_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    // Input bytes
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,    // [7:0] text_byte
    // Results
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,    // [20:0] code_point, [29:21] list_count, [31:30] 0
    output logic [STATUS_W-1:0] m_tuser,    // [1:0] status
    // Configuration
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data    // allow_duplicates
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_SEARCH
    } state_t;

    // Registers
    state_t            state_reg;
    logic              allow_dup_reg;
    logic [1:0]        pending_reg;
    logic [2:0]        seq_len_reg;
    logic [CP_W-1:0]   acc_reg;
    stop_t             stop_reg;
    logic [CNT_W-1:0]  used_reg;
    logic [CNT_W-1:0]  idx_reg;
    logic              cmp_valid_reg;
    logic [CP_W-1:0]   cp_reg;
    logic              m_valid_reg;
    logic [CP_W-1:0]   m_cp_reg;
    logic [STATUS_W-1:0] m_status_reg;
    logic [COUNT_W-1:0]  m_count_reg;

    // Seen table
    logic [CP_W-1:0]   seen_mem [LIST_DEPTH];
    logic [CP_W-1:0]   rd_data_reg;

    // Decoder outputs
    logic [1:0]        pending_next;
    logic [2:0]        seq_len_next;
    logic [CP_W-1:0]   acc_next;
    stop_t             stop_next;
    logic              dec_done;
    logic [CP_W-1:0]   dec_cp;
    logic [STATUS_W-1:0] end_status;

    // Control
    logic              in_acc;
    logic              is_end;
    logic              end_fire;
    logic              list_full;
    logic              full_hit;
    logic              match;
    logic              app_fire;
    logic [CP_W-1:0]   app_cp;
    logic              go_search;
    logic              mem_re;

    assign in_acc    = s_tvalid && s_tready;
    assign is_end    = (s_tdata == '0);
    assign end_fire  = (state_reg == S_IDLE) && in_acc && is_end;
    assign list_full = (used_reg == CNT_W'(LIST_DEPTH));
    assign full_hit  = app_fire && list_full;
    assign match     = cmp_valid_reg && (rd_data_reg == cp_reg);

    assign s_tready  = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {2'b00, m_count_reg, m_cp_reg};
    assign m_tuser   = m_status_reg;

    // Byte decoder: next sequence state for a nonzero byte
    always_comb begin
        logic [CP_W-1:0] shifted;
        logic [1:0]      pend_dec;
        logic            overlong;
        shifted      = {acc_reg[CP_W-7:0], s_tdata[5:0]};
        pend_dec     = pending_reg - 2'd1;
        overlong     = ((seq_len_reg == 3'd2) && (shifted < MIN_CP2)) ||
                       ((seq_len_reg == 3'd3) && (shifted < MIN_CP3)) ||
                       ((seq_len_reg == 3'd4) && (shifted < MIN_CP4));
        pending_next = pending_reg;
        seq_len_next = seq_len_reg;
        acc_next     = acc_reg;
        stop_next    = stop_reg;
        dec_done     = 1'b0;
        dec_cp       = shifted;
        if (stop_reg != STOP_NONE) begin
            // stopped: bytes ignored until the end of text
        end else if (pending_reg == 2'd0) begin
            if (!s_tdata[7]) begin
                dec_done = 1'b1;
                dec_cp   = CP_W'(s_tdata);
            end else if ((s_tdata & MASK_LEAD2) == PAT_LEAD2) begin
                acc_next     = CP_W'(s_tdata & BITS_LEAD2);
                seq_len_next = 3'd2;
                pending_next = 2'd1;
            end else if ((s_tdata & MASK_LEAD3) == PAT_LEAD3) begin
                acc_next     = CP_W'(s_tdata & BITS_LEAD3);
                seq_len_next = 3'd3;
                pending_next = 2'd2;
            end else if ((s_tdata & MASK_LEAD4) == PAT_LEAD4) begin
                acc_next     = CP_W'(s_tdata & BITS_LEAD4);
                seq_len_next = 3'd4;
                pending_next = 2'd3;
            end else begin
                stop_next = STOP_DECODE;
            end
        end else if ((s_tdata & MASK_CONT) != PAT_CONT) begin
            stop_next    = STOP_DECODE;
            pending_next = 2'd0;
        end else begin
            pending_next = pend_dec;
            if (pend_dec != 2'd0) begin
                acc_next = shifted;
            end else begin
                acc_next     = '0;
                seq_len_next = 3'd0;
                if (overlong) begin
                    stop_next = STOP_DECODE;
                end else begin
                    dec_done = 1'b1;
                end
            end
        end
    end

    // End-of-text status; a sequence cut short counts as a decode stop
    always_comb begin
        stop_t eff;
        eff = stop_reg;
        if ((stop_reg == STOP_NONE) && (pending_reg != 2'd0)) begin
            eff = STOP_DECODE;
        end
        unique case (eff)
            STOP_NONE:   end_status = ST_END_NORMAL;
            STOP_DECODE: end_status = ST_END_DECODE;
            STOP_FULL:   end_status = ST_END_FULL;
            default:     end_status = ST_END_NORMAL;
        endcase
    end

    // Append request: straight from the decoder, or at the end of a missed search
    always_comb begin
        go_search = 1'b0;
        app_fire  = 1'b0;
        app_cp    = cp_reg;
        mem_re    = 1'b0;
        if (state_reg == S_IDLE) begin
            if (in_acc && !is_end && dec_done) begin
                if (!allow_dup_reg && (used_reg != '0)) begin
                    go_search = 1'b1;
                end else begin
                    app_fire = 1'b1;
                    app_cp   = dec_cp;
                end
            end
        end else if (!match) begin
            if (idx_reg < used_reg) begin
                mem_re = 1'b1;
            end else begin
                app_fire = 1'b1;
            end
        end
    end

    // Seen-table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (app_fire && !list_full) begin
            seen_mem[used_reg[IDX_W-1:0]] <= app_cp;
        end
        if (mem_re) begin
            rd_data_reg <= seen_mem[idx_reg[IDX_W-1:0]];
        end
    end

    // Control state machine and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            allow_dup_reg <= 1'b0;
            pending_reg   <= '0;
            seq_len_reg   <= '0;
            acc_reg       <= '0;
            stop_reg      <= STOP_NONE;
            used_reg      <= '0;
            idx_reg       <= '0;
            cmp_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                allow_dup_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (in_acc) begin
                        if (is_end) begin
                            m_valid_reg  <= 1'b1;
                            m_cp_reg     <= '0;
                            m_status_reg <= end_status;
                            m_count_reg  <= COUNT_W'(used_reg);
                            pending_reg  <= '0;
                            seq_len_reg  <= '0;
                            acc_reg      <= '0;
                            stop_reg     <= STOP_NONE;
                            used_reg     <= '0;
                        end else begin
                            pending_reg <= pending_next;
                            seq_len_reg <= seq_len_next;
                            acc_reg     <= acc_next;
                            // a full table stops the list
                            stop_reg    <= full_hit ? STOP_FULL : stop_next;
                        end
                    end
                    if (go_search) begin
                        state_reg     <= S_SEARCH;
                        cp_reg        <= dec_cp;
                        idx_reg       <= '0;
                        cmp_valid_reg <= 1'b0;
                    end
                end
                S_SEARCH: begin
                    if (full_hit) begin
                        stop_reg <= STOP_FULL;
                    end
                    if (match || app_fire) begin
                        state_reg     <= S_IDLE;
                        cmp_valid_reg <= 1'b0;
                    end else begin
                        idx_reg       <= idx_reg + CNT_W'(1);
                        cmp_valid_reg <= 1'b1;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
            // Append, or free the result slot once it is taken
            if (app_fire && !list_full) begin
                used_reg     <= used_reg + CNT_W'(1);
                m_valid_reg  <= 1'b1;
                m_cp_reg     <= app_cp;
                m_status_reg <= ST_POINT;
                m_count_reg  <= COUNT_W'(used_reg + CNT_W'(1));
            end else if (!end_fire && m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Assertions
    a_used_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= CNT_W'(LIST_DEPTH))
        else $error("list count beyond table depth");

    a_slot_free_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH) |-> !m_valid_reg)
        else $error("result slot occupied during search");

    a_cmp_only_in_search: assert property (@(posedge aclk) disable iff (!aresetn)
        cmp_valid_reg |-> (state_reg == S_SEARCH))
        else $error("compare pending outside search");

    a_stop_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (stop_reg != STOP_NONE) |-> (pending_reg == 2'd0))
        else $error("sequence pending after stop");

    a_search_idx_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SEARCH) |-> (idx_reg <= used_reg))
        else $error("search index past fill count");

endmodule
